// ===== hw/rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and codes for the linear probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

    localparam int SLOTS_DEFAULT = 1024;
    localparam int KEY_W         = 31;
    localparam int LEN_CFG_W     = 11;
    localparam int OUT_IDX_W     = 10;

    localparam logic [LEN_CFG_W-1:0] TABLE_LENGTH_RESET = 11'd1024;

    // operation codes
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // slot status codes
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE  = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] item_key;
    } in_beat_t;

    typedef struct packed {
        logic                 success;
        logic [OUT_IDX_W-1:0] slot_index;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

endpackage

// ===== hw/rtl/linear_probe_hash_set.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Set of keys in an open addressed table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  in        | in_valid, in_ready, in_data      | sink
//  out       | out_valid, out_ready, out_data   | source
//  cfg       | cfg_wr_en, cfg_wr_data           | sink
//
// For each beat a bit-serial divider forms key mod length, then P slots are
// probed (P from 1 up to the table length), each probe a registered read of
// the slot memory and a check.
// A beat with an unknown operation skips both.
// After reset a clearing pass writes every slot empty, with in_ready low;
// config writes are taken meanwhile.
// A result waiting on out_ready does not block the next input beat; it only
// holds the next result in its last cycle until the output register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_set #(
    parameter int SLOTS = lphs_pkg::SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lphs_pkg::in_beat_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lphs_pkg::out_beat_t                out_data,
    input  logic                               cfg_wr_en,
    input  logic [lphs_pkg::LEN_CFG_W-1:0]     cfg_wr_data
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W  = $clog2(SLOTS + 1);
    localparam int REM_W  = LEN_W + 1;
    localparam int KEY_W  = lphs_pkg::KEY_W;
    localparam int DCNT_W = $clog2(KEY_W);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [lphs_pkg::LEN_CFG_W-1:0] table_length_reg;
    logic [LEN_W-1:0]               used_len;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [1:0]                     op_reg, op_next;
    logic [KEY_W-1:0]               key_reg, key_next;
    logic [KEY_W-1:0]               quo_reg, quo_next;
    logic [REM_W-1:0]               rem_reg, rem_next;
    logic [REM_W-1:0]               rem_shift;
    logic [DCNT_W-1:0]              dcnt_reg, dcnt_next;
    logic [IDX_W-1:0]               pos_reg, pos_next;
    logic [LEN_W-1:0]               cnt_reg, cnt_next;
    logic [LEN_W-1:0]               pos_inc;
    logic [IDX_W-1:0]               clr_reg, clr_next;
    logic                           ok_reg, ok_next;
    logic [IDX_W-1:0]               where_reg, where_next;
    logic                           out_valid_reg, out_valid_next;
    lphs_pkg::out_beat_t            out_data_reg, out_data_next;

    lphs_pkg::slot_entry_t          mem [SLOTS];
    lphs_pkg::slot_entry_t          rd_q_reg;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    lphs_pkg::slot_entry_t          mem_wdata;
    logic                           hit;

    // length 0 acts as 1, lengths above SLOTS saturate
    always_comb
    begin
        if (table_length_reg == '0)
            used_len = LEN_W'(1);
        else if (32'(table_length_reg) > SLOTS)
            used_len = LEN_W'(SLOTS);
        else
            used_len = LEN_W'(table_length_reg);
    end

    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[KEY_W-1]};
    assign pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);
    assign hit       = (rd_q_reg.status == lphs_pkg::SLOT_ACTIVE) && (rd_q_reg.key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        ok_next        = ok_reg;
        where_next     = where_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = '{status: lphs_pkg::SLOT_ACTIVE, key: key_reg};

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '{status: lphs_pkg::SLOT_EMPTY, key: '0};
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(SLOTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.operation;
                    key_next   = in_data.item_key;
                    quo_next   = in_data.item_key;
                    len_next   = used_len;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    cnt_next   = '0;
                    ok_next    = 1'b0;
                    where_next = '0;
                    if (in_data.operation == lphs_pkg::OP_FIND ||
                        in_data.operation == lphs_pkg::OP_INSERT ||
                        in_data.operation == lphs_pkg::OP_REMOVE)
                        state_next = ST_DIV;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one key bit per cycle
                if (rem_shift >= REM_W'(len_reg))
                    rem_next = rem_shift - REM_W'(len_reg);
                else
                    rem_next = rem_shift;
                quo_next  = {quo_reg[KEY_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(KEY_W - 1))
                begin
                    pos_next   = IDX_W'(rem_next);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg == lphs_pkg::OP_INSERT)
                begin
                    if (hit)
                    begin
                        ok_next    = 1'b1;
                        where_next = pos_reg;
                        state_next = ST_FINISH;
                    end
                    else if (rd_q_reg.status != lphs_pkg::SLOT_ACTIVE)
                    begin
                        mem_we     = 1'b1;
                        ok_next    = 1'b1;
                        where_next = pos_reg;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    if (rd_q_reg.status == lphs_pkg::SLOT_EMPTY)
                        state_next = ST_FINISH;
                    else if (hit)
                    begin
                        if (op_reg == lphs_pkg::OP_REMOVE)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{status: lphs_pkg::SLOT_DELETED, key: rd_q_reg.key};
                        end
                        ok_next    = 1'b1;
                        where_next = pos_reg;
                        state_next = ST_FINISH;
                    end
                end
                // no stop: step to the next slot, give up after len probes
                if (state_next == ST_CHECK)
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                    if (cnt_next == len_reg)
                        state_next = ST_FINISH;
                    else
                    begin
                        pos_next   = (pos_inc >= len_reg) ? '0 : IDX_W'(pos_inc);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.success    = ok_reg;
                    out_data_next.slot_index = ok_reg ?
                        lphs_pkg::OUT_IDX_W'(where_reg) : '0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
            table_length_reg <= lphs_pkg::TABLE_LENGTH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                table_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        ok_reg       <= ok_next;
        where_reg    <= where_next;
        out_data_reg <= out_data_next;
    end

    // slot store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_q_reg <= mem[pos_reg];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/lphs_checker.sv =====
// ----------------------------------------------------------------------------
// lphs_checker
// Port-level checks for the linear probing hash set, bound to the top level.
// ----------------------------------------------------------------------------
module lphs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input lphs_pkg::in_beat_t             in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input lphs_pkg::out_beat_t            out_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled out beat changed");

    // a stalled request beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("stalled in beat changed");

    // a miss never reports a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.success |-> out_data.slot_index == '0)
        else $error("failed result carries a slot index");

    // the block is busy in the cycle after it takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again too soon");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);

// ===== verif/lphs_checker.sv =====
// ----------------------------------------------------------------------------
// lphs_scoreboard
// Watches the request, answer and config ports of the hash set, keeps its
// own copy of the slot table and compares every answer beat, field by field,
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module lphs_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  lphs_pkg::in_beat_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  lphs_pkg::out_beat_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [lphs_pkg::LEN_CFG_W-1:0] cfg_wr_data,
    output int                             outstanding,
    output int                             errors,
    output int                             compared
);

    logic [lphs_pkg::KEY_W-1:0]     slot_key   [lphs_pkg::SLOTS_DEFAULT];
    logic [1:0]                     slot_state [lphs_pkg::SLOTS_DEFAULT];
    logic [lphs_pkg::LEN_CFG_W-1:0] table_len;
    lphs_pkg::out_beat_t            pending_answers [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        errors++;
    endtask

    // Walks the probe sequence for one request, updates the table and
    // returns the answer the block should give.
    function automatic lphs_pkg::out_beat_t apply_request(input lphs_pkg::in_beat_t req);
        int unsigned         span;
        int unsigned         pos;
        logic                matched;
        lphs_pkg::out_beat_t answer;
        answer = '0;
        span = (table_len == 0) ? 1 :
               (table_len > lphs_pkg::SLOTS_DEFAULT) ? lphs_pkg::SLOTS_DEFAULT :
               int'(table_len);
        if (req.operation == lphs_pkg::OP_FIND || req.operation == lphs_pkg::OP_INSERT ||
            req.operation == lphs_pkg::OP_REMOVE)
        begin
            pos = req.item_key % span;
            for (int unsigned n = 0; n < span; n++)
            begin
                matched = (slot_state[pos] == lphs_pkg::SLOT_ACTIVE) &&
                          (slot_key[pos] == req.item_key);
                if (req.operation == lphs_pkg::OP_INSERT)
                begin
                    // first matching or non-active slot wins, later duplicates are not looked for
                    if (matched || slot_state[pos] != lphs_pkg::SLOT_ACTIVE)
                    begin
                        if (!matched)
                        begin
                            slot_key[pos]   = req.item_key;
                            slot_state[pos] = lphs_pkg::SLOT_ACTIVE;
                        end
                        answer.success    = 1'b1;
                        answer.slot_index = pos[lphs_pkg::OUT_IDX_W-1:0];
                        break;
                    end
                end
                else
                begin
                    if (slot_state[pos] == lphs_pkg::SLOT_EMPTY)
                        break;
                    if (matched)
                    begin
                        if (req.operation == lphs_pkg::OP_REMOVE)
                            slot_state[pos] = lphs_pkg::SLOT_DELETED;
                        answer.success    = 1'b1;
                        answer.slot_index = pos[lphs_pkg::OUT_IDX_W-1:0];
                        break;
                    end
                end
                pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lphs_pkg::out_beat_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < lphs_pkg::SLOTS_DEFAULT; s++)
            begin
                slot_state[s] = lphs_pkg::SLOT_EMPTY;
                slot_key[s]   = '0;
            end
            table_len = lphs_pkg::TABLE_LENGTH_RESET;
            pending_answers.delete();
            errors      = 0;
            compared    = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch($sformatf("answer beat %p with nothing pending", out_data));
                else
                begin
                    want = pending_answers.pop_front();
                    compared++;
                    if (out_data.success !== want.success)
                        report_mismatch($sformatf("success got %b want %b",
                                                  out_data.success, want.success));
                    if (out_data.slot_index !== want.slot_index)
                        report_mismatch($sformatf("slot_index got %0d want %0d",
                                                  out_data.slot_index, want.slot_index));
                end
            end
            if (in_valid && in_ready)
                pending_answers.push_back(apply_request(in_data));
            if (cfg_wr_en)
                table_len = cfg_wr_data;
            outstanding <= pending_answers.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives find, insert, remove and unused-opcode beats into the hash set over a
// series of table lengths, with bursty requests and a stalling answer side. A
// separate checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0]                 OP_UNUSED    = 2'd3;
    localparam int                         RUN_LIMIT    = 8_000_000;
    localparam int                         DRAIN_CYCLES = 2200;
    localparam int                         PHASE_ITEMS  = 40;
    localparam logic [lphs_pkg::KEY_W-1:0] KEY_MAX      = '1;

    typedef enum int {RX_STREAM, RX_CHOPPY, RX_STARVED} rx_mode_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    lphs_pkg::in_beat_t             in_data     = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    lphs_pkg::out_beat_t            out_data;
    logic                           cfg_wr_en   = 1'b0;
    logic [lphs_pkg::LEN_CFG_W-1:0] cfg_wr_data = '0;

    int          outstanding;
    int          errors;
    int          compared;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned eff_len     = lphs_pkg::SLOTS_DEFAULT;
    int unsigned settings    = 0;
    int unsigned op_count [4] = '{0, 0, 0, 0};
    logic [lphs_pkg::KEY_W-1:0] used_keys [$];

    rx_mode_t    rx_mode = RX_STREAM;
    int unsigned rx_left = 0;

    always #4 clk = ~clk;

    linear_probe_hash_set #(.SLOTS(lphs_pkg::SLOTS_DEFAULT)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lphs_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .outstanding (outstanding),
        .errors      (errors),
        .compared    (compared)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("linear_probe_hash_set test failed");
            $finish;
        end
    end

    // answer side: free running, choppy or mostly stalled, switching now and then
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(30, 300);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_STREAM:  out_ready <= 1'b1;
            RX_CHOPPY:  out_ready <= ($urandom_range(0, 1) == 1);
            default:    out_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    task automatic send_beat(input logic [1:0] op, input logic [lphs_pkg::KEY_W-1:0] key);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{operation: op, item_key: key};
        op_count[op]++;
        if (op == lphs_pkg::OP_INSERT)
        begin
            used_keys.push_back(key);
            if (used_keys.size() > 48)
                void'(used_keys.pop_front());
        end
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // hold off requests until every answer has come back
    task automatic wait_drained;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic set_length(input logic [lphs_pkg::LEN_CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eff_len = (value == 0) ? 1 :
                  (value > lphs_pkg::SLOTS_DEFAULT) ? lphs_pkg::SLOTS_DEFAULT : value;
        settings++;
    endtask

    // keys: reuse of earlier inserts, colliders on one home slot, extremes, noise
    function automatic logic [lphs_pkg::KEY_W-1:0] pick_key(input int unsigned reuse_weight);
        int unsigned home;
        logic [63:0] wide;
        if (used_keys.size() != 0 && $urandom_range(0, 9) < reuse_weight)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        case ($urandom_range(0, 5))
            0, 1:
            begin
                home = ($urandom_range(0, 1) == 1) ? eff_len - 1 :
                       $urandom_range(0, eff_len - 1);
                wide = 64'(home) + 64'(eff_len) * 64'($urandom_range(0, 2097151));
                return wide[lphs_pkg::KEY_W-1:0];
            end
            2: return ($urandom_range(0, 1) == 1) ? KEY_MAX :
                      KEY_MAX - lphs_pkg::KEY_W'($urandom_range(0, 3000));
            3: return ($urandom_range(0, 1) == 1) ? '0 :
                      lphs_pkg::KEY_W'($urandom_range(0, 2 * eff_len));
            default: return lphs_pkg::KEY_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned                    sel;
        logic [1:0]                     op;
        logic [lphs_pkg::LEN_CFG_W-1:0] len_plan [14];
        len_plan = '{11'd1, 11'd2, 11'd3, 11'd7, 11'd16, 11'd64, 11'd1024,
                     11'd0, 11'd200, 11'd1000, 11'd5, 11'd2047, 11'd33, 11'd512};
        len_plan[8]  = lphs_pkg::LEN_CFG_W'($urandom_range(17, 2047));
        len_plan[13] = lphs_pkg::LEN_CFG_W'($urandom_range(2, 1024));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset length; collisions, wrap at the top slot, tombstones
        send_beat(lphs_pkg::OP_FIND,   '0);
        send_beat(lphs_pkg::OP_INSERT, '0);
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(1024));
        send_beat(lphs_pkg::OP_INSERT, KEY_MAX);
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(2047));
        send_beat(lphs_pkg::OP_FIND,   lphs_pkg::KEY_W'(2047));
        send_beat(lphs_pkg::OP_INSERT, '0);
        send_beat(lphs_pkg::OP_REMOVE, lphs_pkg::KEY_W'(1024));
        send_beat(lphs_pkg::OP_FIND,   lphs_pkg::KEY_W'(2047));
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(3072));
        send_beat(lphs_pkg::OP_REMOVE, '0);
        // key already further down the chain; insert still takes the tombstone
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(2047));
        send_beat(lphs_pkg::OP_REMOVE, lphs_pkg::KEY_W'(5));
        send_beat(OP_UNUSED, '0);
        send_beat(OP_UNUSED, KEY_MAX);

        // zero length acts as one slot: full table on a miss
        set_length('0);
        send_beat(lphs_pkg::OP_FIND,   lphs_pkg::KEY_W'(2047));
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(9));
        send_beat(lphs_pkg::OP_REMOVE, lphs_pkg::KEY_W'(2047));
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(9));

        // oversize length saturates; old contents still there
        set_length('1);
        send_beat(lphs_pkg::OP_FIND, KEY_MAX);
        send_beat(lphs_pkg::OP_FIND, lphs_pkg::KEY_W'(3072));
        send_beat(lphs_pkg::OP_FIND, lphs_pkg::KEY_W'(9));

        // shrink onto filled slots: every probe runs around the whole table
        set_length(11'd3);
        send_beat(lphs_pkg::OP_INSERT, lphs_pkg::KEY_W'(4));
        send_beat(lphs_pkg::OP_FIND,   lphs_pkg::KEY_W'(6));

        foreach (len_plan[p])
        begin
            set_length(len_plan[p]);
            repeat (PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 8)
                    op = lphs_pkg::OP_INSERT;
                else if (sel < 14)
                    op = lphs_pkg::OP_FIND;
                else if (sel < 19)
                    op = lphs_pkg::OP_REMOVE;
                else
                    op = OP_UNUSED;
                send_beat(op, pick_key(op == lphs_pkg::OP_INSERT ? 3 : 7));
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d finds, %0d inserts, %0d removes, %0d bad opcodes across %0d lengths",
                 op_count[lphs_pkg::OP_FIND], op_count[lphs_pkg::OP_INSERT],
                 op_count[lphs_pkg::OP_REMOVE], op_count[OP_UNUSED], settings);
        $display("%0d answers compared, %0d mismatches", compared, errors);
        if (errors == 0)
            $display("linear_probe_hash_set test passed");
        else
            $display("linear_probe_hash_set test failed");
        $finish;
    end

endmodule
